// ===== rtl/tss_pkg.sv =====
// Shared types and constants for the two-sided stack.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tss_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned MaxAddrW = 16;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic SIDE_FRONT = 1'b0;
  localparam logic SIDE_BACK  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic                    op;
    logic                    side;
    logic signed [DataW-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] data_out;
    logic [1:0]              status;
  } out_item_t;

  // Command handed from the classifier to the storage side.
  typedef struct packed {
    logic                wr;
    logic                rd;
    logic [1:0]          status;
    logic [MaxAddrW-1:0] addr;
    logic [DataW-1:0]    data;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/two_sided_stack_top.sv =====
// Top level of the two-sided stack: front end, command queue and back end.
// Depends on tss_pkg, tss_front, tss_fifo and tss_back.
`default_nettype none

// Two stacks in one store of DEPTH words: side 0 grows up from word 0, side 1
// grows down from the top word. Every item (push or pop on one side) gives one
// result with a status. Items are taken one per cycle while results drain; the
// front end decides status and address from the two stack counts at once, the
// command is written into the queue, and the back end does the store access
// as it takes the command from the queue and loads the result register.
// A two-entry command queue lets either side stall without stopping the other;
// with the output stalled, the input stalls once two more items fill the queue.
// The store is not cleared at reset; pops only read words that were pushed.
module two_sided_stack_top #(
  parameter int unsigned DEPTH = 128
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  tss_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output tss_pkg::out_item_t out_item_o
);

  tss_pkg::cmd_t cmd_in, cmd_out;
  logic          q_full, q_empty, q_pop, in_take;

  assign in_stall_o = q_full;
  assign in_take    = in_valid_i && !q_full;

  tss_front #(.DEPTH(DEPTH)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (in_take),
    .item_i (in_item_i),
    .cmd_o  (cmd_in)
  );

  tss_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_take),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (cmd_out),
    .empty_o (q_empty)
  );

  tss_back #(.DEPTH(DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_valid_i (!q_empty),
    .cmd_take_o  (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== rtl/tss_front.sv =====
// Front end: accepts items, checks fill levels, keeps both stack counts and
// turns each item into a storage command. Depends on tss_pkg.
`default_nettype none

module tss_front #(
  parameter int unsigned DEPTH = 128
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               take_i,
  input  tss_pkg::in_item_t item_i,
  output tss_pkg::cmd_t     cmd_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0] front_q, front_d;
  logic [CW-1:0] back_q, back_d;
  logic [CW:0]   sum;
  logic          full;
  logic          empty_sel;
  logic [AW-1:0] addr;
  logic [CW-1:0] back_pop_pos;
  logic [CW-1:0] front_pop_pos;

  assign sum           = {1'b0, front_q} + {1'b0, back_q};
  assign full          = sum >= (CW+1)'(DEPTH);
  assign empty_sel     = (item_i.side == tss_pkg::SIDE_FRONT) ? (front_q == '0)
                                                              : (back_q == '0);
  assign back_pop_pos  = CW'(DEPTH) - back_q;
  assign front_pop_pos = front_q - CW'(1);

  always_comb begin
    front_d = front_q;
    back_d  = back_q;
    addr    = '0;
    cmd_o   = '0;
    if (item_i.op == tss_pkg::OP_PUSH) begin
      cmd_o.data = item_i.data_in;
      if (full) begin
        cmd_o.status = tss_pkg::ST_OVERFLOW;
      end else begin
        cmd_o.status = tss_pkg::ST_OK;
        cmd_o.wr     = 1'b1;
        if (item_i.side == tss_pkg::SIDE_FRONT) begin
          addr    = front_q[AW-1:0];
          front_d = front_q + CW'(1);
        end else begin
          addr   = AW'(DEPTH - 1) - back_q[AW-1:0];
          back_d = back_q + CW'(1);
        end
      end
    end else begin
      if (empty_sel) begin
        cmd_o.status = tss_pkg::ST_UNDERFLOW;
      end else begin
        cmd_o.status = tss_pkg::ST_OK;
        cmd_o.rd     = 1'b1;
        if (item_i.side == tss_pkg::SIDE_FRONT) begin
          addr    = front_pop_pos[AW-1:0];
          front_d = front_pop_pos;
        end else begin
          addr   = back_pop_pos[AW-1:0];
          back_d = back_q - CW'(1);
        end
      end
    end
    cmd_o.addr = tss_pkg::MaxAddrW'(addr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
    end else if (take_i) begin
      front_q <= front_d;
      back_q  <= back_d;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, front_q} + {1'b0, back_q}) <= (CW+1)'(DEPTH))
    else $error("stack counts exceed store depth");

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && cmd_o.status != tss_pkg::ST_OK) |=> ($stable(front_q) && $stable(back_q)))
    else $error("rejected item changed a stack count");

endmodule

`default_nettype wire

// ===== rtl/tss_fifo.sv =====
// Two-entry command queue between the classifier and the storage side.
// Depends on tss_pkg.
`default_nettype none

module tss_fifo (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           push_i,
  input  tss_pkg::cmd_t data_i,
  output logic          full_o,
  input  wire           pop_i,
  output tss_pkg::cmd_t data_o,
  output logic          empty_o
);

  tss_pkg::cmd_t slot_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && empty_o))
    else $error("command queue overrun or underrun");

endmodule

`default_nettype wire

// ===== rtl/tss_back.sv =====
// Back end: holds the shared store, runs queued commands one per cycle unless
// a stalled result blocks them, keeps the result register. Depends on tss_pkg.
`default_nettype none

module tss_back #(
  parameter int unsigned DEPTH = 128
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  tss_pkg::cmd_t      cmd_i,
  input  wire                cmd_valid_i,
  output logic               cmd_take_o,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output tss_pkg::out_item_t out_item_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [tss_pkg::DataW-1:0] mem_q [DEPTH];
  logic [tss_pkg::DataW-1:0] rdata_q;
  logic                      valid_q;
  logic                      is_read_q;
  logic [1:0]                status_q;
  logic [AW-1:0]             idx;

  assign idx        = cmd_i.addr[AW-1:0];
  assign cmd_take_o = cmd_valid_i && (!valid_q || !out_stall_i);

  always_ff @(posedge clk_i) begin
    if (cmd_take_o && cmd_i.wr) begin
      mem_q[idx] <= cmd_i.data;
    end
    if (cmd_take_o && cmd_i.rd) begin
      rdata_q <= mem_q[idx];
    end
    if (cmd_take_o) begin
      is_read_q <= cmd_i.rd;
      status_q  <= cmd_i.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_take_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // Underflow returns all ones, push results return zero.
  always_comb begin
    out_item_o.status = status_q;
    if (is_read_q) begin
      out_item_o.data_out = rdata_q;
    end else if (status_q == tss_pkg::ST_UNDERFLOW) begin
      out_item_o.data_out = '1;
    end else begin
      out_item_o.data_out = '0;
    end
  end

  assign out_valid_o = valid_q;

  a_take_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take_o |=> valid_q)
    else $error("taken command produced no result");

endmodule

`default_nettype wire
